// ===== rtl/tdia_pkg.sv =====
// Shared types and constants for the tuple dedup id assigner.
// Used by the controller, the datapath and the top level.
`default_nettype none

package tdia_pkg;

   // Default sizes for the top level parameters
   localparam int DEFAULT_TABLE_DEPTH = 256;
   localparam int DEFAULT_COMP_WIDTH  = 5;

   // Fixed result id width and tuple makeup
   localparam int ID_W   = 8;
   localparam int N_COMP = 6;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;    // latch the key and restart the scan
      logic issue;   // read both tables at the scan address and advance
      logic commit;  // resolve the lookups, update the tables, register the result
   } tdia_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_done;  // scan address has passed every stored entry
   } tdia_status_type;

endpackage

`default_nettype wire

// ===== rtl/tdia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tdia_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tdia_datapath.sv =====
// Datapath: key registers, scan address, both tuple tables, match tracking,
// entry counts and result registers. Depends on tdia_pkg and tdia_ram.
`default_nettype none

module tdia_datapath #(
   parameter int TABLE_DEPTH = 256,
   parameter int COMP_WIDTH  = 5
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tdia_pkg::tdia_cmd_type      cmd,
   output tdia_pkg::tdia_status_type        status,
   input  wire logic signed [COMP_WIDTH-1:0] req_dis_x,
   input  wire logic signed [COMP_WIDTH-1:0] req_dis_y,
   input  wire logic signed [COMP_WIDTH-1:0] req_dis_z,
   input  wire logic signed [COMP_WIDTH-1:0] req_mom_x,
   input  wire logic signed [COMP_WIDTH-1:0] req_mom_y,
   input  wire logic signed [COMP_WIDTH-1:0] req_mom_z,
   output logic [tdia_pkg::ID_W-1:0]        rsp_full_id,
   output logic [tdia_pkg::ID_W-1:0]        rsp_pair_id,
   output logic                             rsp_new_pair_entry,
   output logic                             rsp_mom_flipped,
   output logic                             rsp_table_full
);

   import tdia_pkg::*;

   localparam int TUP_W = N_COMP * COMP_WIDTH;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Search keys
   logic [TUP_W-1:0] key_ff, key_in;
   logic [TUP_W-1:0] neg_key_ff, neg_key_in;

   // Scan address and the read in flight
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_addr_ff;

   // Match tracking
   logic             found_full_ff, found_full_in;
   logic [IDX_W-1:0] full_idx_ff, full_idx_in;
   logic             found_exact_ff, found_exact_in;
   logic [IDX_W-1:0] exact_idx_ff, exact_idx_in;
   logic             found_neg_ff, found_neg_in;
   logic [IDX_W-1:0] neg_idx_ff, neg_idx_in;

   // Entry counts
   logic [CNT_W-1:0] full_count_ff, full_count_in;
   logic [CNT_W-1:0] pair_count_ff, pair_count_in;

   // Table ports
   logic [TUP_W-1:0] full_rd_data, pair_rd_data;
   logic             full_wr_en, pair_wr_en;

   // Result registers
   logic [ID_W-1:0] full_id_ff, full_id_in;
   logic [ID_W-1:0] pair_id_ff, pair_id_in;
   logic            new_pair_ff, new_pair_in;
   logic            negm_ff, negm_in;
   logic            overflow_ff, overflow_in;

   logic [COMP_WIDTH-1:0] neg_mom_x, neg_mom_y, neg_mom_z;
   logic [CNT_W-1:0]      scan_limit;
   logic                  full_in_range, pair_in_range;
   logic                  hit_full, hit_exact, hit_neg;

   // Negate momentum, wrapping within the component width
   assign neg_mom_x = COMP_WIDTH'(0) - req_mom_x;
   assign neg_mom_y = COMP_WIDTH'(0) - req_mom_y;
   assign neg_mom_z = COMP_WIDTH'(0) - req_mom_z;

   // Scan runs to the larger of the two counts
   assign scan_limit       = (full_count_ff > pair_count_ff) ? full_count_ff : pair_count_ff;
   assign status.scan_done = (addr_ff >= scan_limit);

   // Compare the entries that came back from the tables
   assign full_in_range = (CNT_W'(rd_addr_ff) < full_count_ff);
   assign pair_in_range = (CNT_W'(rd_addr_ff) < pair_count_ff);
   assign hit_full  = rd_valid_ff && full_in_range && (full_rd_data == key_ff);
   assign hit_exact = rd_valid_ff && pair_in_range && (pair_rd_data == key_ff);
   assign hit_neg   = rd_valid_ff && pair_in_range && (pair_rd_data == neg_key_ff);

   assign full_wr_en = cmd.commit && !found_full_ff && (full_count_ff < DEPTH_CNT);
   assign pair_wr_en = cmd.commit && !found_exact_ff && !found_neg_ff
                       && (pair_count_ff < DEPTH_CNT);

   tdia_ram #(
      .WIDTH (TUP_W),
      .DEPTH (TABLE_DEPTH)
   ) u_full_table (
      .clock   (clock),
      .wr_en   (full_wr_en),
      .wr_addr (full_count_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (full_rd_data)
   );

   tdia_ram #(
      .WIDTH (TUP_W),
      .DEPTH (TABLE_DEPTH)
   ) u_pair_table (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_count_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (pair_rd_data)
   );

   // Next-state logic for keys, scan address and match tracking
   always_comb begin
      key_in         = key_ff;
      neg_key_in     = neg_key_ff;
      addr_in        = addr_ff;
      found_full_in  = found_full_ff;
      full_idx_in    = full_idx_ff;
      found_exact_in = found_exact_ff;
      exact_idx_in   = exact_idx_ff;
      found_neg_in   = found_neg_ff;
      neg_idx_in     = neg_idx_ff;

      if (cmd.load) begin
         key_in         = {req_dis_x, req_dis_y, req_dis_z, req_mom_x, req_mom_y, req_mom_z};
         neg_key_in     = {req_dis_x, req_dis_y, req_dis_z, neg_mom_x, neg_mom_y, neg_mom_z};
         addr_in        = '0;
         found_full_in  = 1'b0;
         found_exact_in = 1'b0;
         found_neg_in   = 1'b0;
      end else begin
         if (cmd.issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
         // Keep the first match of each kind
         if (hit_full && !found_full_ff) begin
            found_full_in = 1'b1;
            full_idx_in   = rd_addr_ff;
         end
         if (hit_exact && !found_exact_ff) begin
            found_exact_in = 1'b1;
            exact_idx_in   = rd_addr_ff;
         end
         if (hit_neg && !found_neg_ff) begin
            found_neg_in = 1'b1;
            neg_idx_in   = rd_addr_ff;
         end
      end
   end

   // Resolve both lookups at commit
   always_comb begin
      full_count_in = full_count_ff;
      pair_count_in = pair_count_ff;
      full_id_in    = full_id_ff;
      pair_id_in    = pair_id_ff;
      new_pair_in   = new_pair_ff;
      negm_in       = negm_ff;
      overflow_in   = overflow_ff;

      if (cmd.commit) begin
         full_id_in  = '0;
         pair_id_in  = '0;
         new_pair_in = 1'b0;
         negm_in     = 1'b0;
         overflow_in = 1'b0;

         // First table: exact match or a new entry
         priority if (found_full_ff) begin
            full_id_in = ID_W'(full_idx_ff);
         end else if (full_count_ff < DEPTH_CNT) begin
            full_id_in    = ID_W'(full_count_ff);
            full_count_in = full_count_ff + CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end

         // Second table: exact, then negated momentum, then a new entry
         priority if (found_exact_ff) begin
            pair_id_in = ID_W'(exact_idx_ff);
         end else if (found_neg_ff) begin
            pair_id_in = ID_W'(neg_idx_ff);
            negm_in    = 1'b1;
         end else if (pair_count_ff < DEPTH_CNT) begin
            pair_id_in    = ID_W'(pair_count_ff);
            pair_count_in = pair_count_ff + CNT_W'(1);
            new_pair_in   = 1'b1;
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         full_count_ff <= '0;
         pair_count_ff <= '0;
      end else begin
         rd_valid_ff   <= cmd.issue;
         full_count_ff <= full_count_in;
         pair_count_ff <= pair_count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      neg_key_ff     <= neg_key_in;
      addr_ff        <= addr_in;
      rd_addr_ff     <= addr_ff[IDX_W-1:0];
      found_full_ff  <= found_full_in;
      full_idx_ff    <= full_idx_in;
      found_exact_ff <= found_exact_in;
      exact_idx_ff   <= exact_idx_in;
      found_neg_ff   <= found_neg_in;
      neg_idx_ff     <= neg_idx_in;
      full_id_ff     <= full_id_in;
      pair_id_ff     <= pair_id_in;
      new_pair_ff    <= new_pair_in;
      negm_ff        <= negm_in;
      overflow_ff    <= overflow_in;
   end

   assign rsp_full_id        = full_id_ff;
   assign rsp_pair_id        = pair_id_ff;
   assign rsp_new_pair_entry = new_pair_ff;
   assign rsp_mom_flipped    = negm_ff;
   assign rsp_table_full     = overflow_ff;

endmodule

`default_nettype wire

// ===== rtl/tdia_ctrl.sv =====
// Controller state machine: sequences load, table scan, drain and commit.
// Depends on tdia_pkg.
`default_nettype none

module tdia_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   output logic                            rsp_valid,
   output tdia_pkg::tdia_cmd_type          cmd,
   input  wire tdia_pkg::tdia_status_type  status
);

   import tdia_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   // Decode commands from the current state
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.issue  = (state_ff == ST_SCAN) && !status.scan_done;
   assign cmd.commit = (state_ff == ST_COMMIT);

   // Advance through the lookup
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.commit;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/tuple_dedup_id_assigner_core.sv =====
// Top level of the tuple dedup id assigner: controller plus datapath.
// Depends on tdia_pkg, tdia_ctrl, tdia_datapath and tdia_ram.
//
// Usage:
//   Input: drive the six components on req_* and raise start; the transaction
//   is taken at a rising edge where start is high and busy is low.
//   Output: one result per input transaction, shown on rsp_* for exactly one
//   cycle with rsp_valid high. The receiver cannot stall; the result must be
//   taken in that cycle.
//   Timing: each lookup scans both tables up to the larger of the two entry
//   counts, at most TABLE_DEPTH entries; busy drops in the result cycle, so
//   the next transaction may start then. The lookup time is set by the linear
//   scan of both tables, which read one entry of each per cycle through the
//   single read port of each table RAM.
//   Reset clears both entry counts and the controller; the table contents are
//   not cleared, since entries at or above the counts are never used.
//   When a table is full and needs a new entry, rsp_table_full is raised and
//   that table's id reads zero.
`default_nettype none

module tuple_dedup_id_assigner_core #(
   parameter int TABLE_DEPTH = tdia_pkg::DEFAULT_TABLE_DEPTH,
   parameter int COMP_WIDTH  = tdia_pkg::DEFAULT_COMP_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COMP_WIDTH-1:0] req_dis_x,
   input  wire logic signed [COMP_WIDTH-1:0] req_dis_y,
   input  wire logic signed [COMP_WIDTH-1:0] req_dis_z,
   input  wire logic signed [COMP_WIDTH-1:0] req_mom_x,
   input  wire logic signed [COMP_WIDTH-1:0] req_mom_y,
   input  wire logic signed [COMP_WIDTH-1:0] req_mom_z,
   output logic                              rsp_valid,
   output logic [tdia_pkg::ID_W-1:0]         rsp_full_id,
   output logic [tdia_pkg::ID_W-1:0]         rsp_pair_id,
   output logic                              rsp_new_pair_entry,
   output logic                              rsp_mom_flipped,
   output logic                              rsp_table_full
);

   import tdia_pkg::*;

   tdia_cmd_type    cmd;
   tdia_status_type status;

   tdia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   tdia_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COMP_WIDTH  (COMP_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_dis_x          (req_dis_x),
      .req_dis_y          (req_dis_y),
      .req_dis_z          (req_dis_z),
      .req_mom_x          (req_mom_x),
      .req_mom_y          (req_mom_y),
      .req_mom_z          (req_mom_z),
      .rsp_full_id        (rsp_full_id),
      .rsp_pair_id        (rsp_pair_id),
      .rsp_new_pair_entry (rsp_new_pair_entry),
      .rsp_mom_flipped    (rsp_mom_flipped),
      .rsp_table_full     (rsp_table_full)
   );

endmodule

`default_nettype wire
